// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/arc_pkg.sv
// ----------------------------------------------------------------------------
// ASCII radix converter package
// Shared types, character constants and a helper function.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int VALUE_BITS_DEFAULT = 16;
    localparam int CHAR_W             = 8;
    localparam int NUMBER_W           = 16;
    localparam int RADIX_W            = 2;
    localparam int KIND_W             = 2;
    localparam int HEX_LETTER_BASE    = 10;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'd57;
    localparam logic [CHAR_W-1:0] CH_A    = 8'd65;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_BIN = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE = 2'd0,
        KIND_BIN   = 2'd1,
        KIND_HEX   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPORT,
        S_BIN,
        S_HEX
    } state_t;

    typedef struct packed {
        logic  fold;
        logic  scan;
        logic  emit;
        kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic bin_done;
        logic hex_done;
        logic bin_zero;
        logic bin_last;
        logic hex_last;
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'(HEX_LETTER_BASE)) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_A + CHAR_W'(d) - CHAR_W'(HEX_LETTER_BASE);
        end
        return c;
    endfunction

endpackage

// File: design/arc_datapath.sv
// ----------------------------------------------------------------------------
// ASCII radix converter datapath
// Radix register, accumulator, leading-zero scan shifters and output register.
// ----------------------------------------------------------------------------
module arc_datapath #(
    parameter int VALUE_BITS = arc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [arc_pkg::RADIX_W-1:0]       cfg_wdata,
    input  logic [arc_pkg::CHAR_W-1:0]        s_char_code,
    input  logic                              s_last_char,
    input  arc_pkg::dp_cmd_t                  cmd,
    output arc_pkg::dp_status_t               status,
    output logic [arc_pkg::KIND_W-1:0]        m_result_kind,
    output logic [arc_pkg::NUMBER_W-1:0]      m_number_value,
    output logic [arc_pkg::CHAR_W-1:0]        m_digit_char,
    output logic                              m_last_of_run
);

    localparam int NIB    = (VALUE_BITS + 3) / 4;
    localparam int HEX_W  = 4 * NIB;
    localparam int BCNT_W = $clog2(VALUE_BITS + 1);
    localparam int HCNT_W = $clog2(NIB + 1);

    arc_pkg::radix_t             radix_reg;
    logic [VALUE_BITS-1:0]       acc_reg;
    logic [VALUE_BITS-1:0]       val_reg;
    logic [VALUE_BITS-1:0]       bin_sh_reg;
    logic [HEX_W-1:0]            hex_sh_reg;
    logic [BCNT_W-1:0]           bin_cnt_reg;
    logic [HCNT_W-1:0]           hex_cnt_reg;
    logic [arc_pkg::KIND_W-1:0]  kind_reg;
    logic [arc_pkg::NUMBER_W-1:0] number_reg;
    logic [arc_pkg::CHAR_W-1:0]  char_reg;
    logic                        last_reg;

    logic                        is_hex;
    logic                        is_dec_char;
    logic [VALUE_BITS-1:0]       char_ext;
    logic [VALUE_BITS-1:0]       digit;
    logic [VALUE_BITS-1:0]       scaled;
    logic [VALUE_BITS-1:0]       acc_next;
    logic                        bin_msb;
    logic [3:0]                  hex_top;
    logic [arc_pkg::CHAR_W-1:0]  char_next;
    logic                        last_next;

    assign is_hex      = (radix_reg != arc_pkg::RADIX_BIN) && (radix_reg != arc_pkg::RADIX_DEC);
    assign is_dec_char = (s_char_code >= arc_pkg::CH_ZERO) && (s_char_code <= arc_pkg::CH_NINE);
    assign char_ext    = VALUE_BITS'(s_char_code);

    always_comb begin
        if (is_hex && !is_dec_char) begin
            digit = char_ext - VALUE_BITS'(arc_pkg::CH_A)
                  + VALUE_BITS'(arc_pkg::HEX_LETTER_BASE);
        end else begin
            digit = char_ext - VALUE_BITS'(arc_pkg::CH_ZERO);
        end
    end

    always_comb begin
        unique case (radix_reg)
            arc_pkg::RADIX_BIN: scaled = acc_reg << 1;
            arc_pkg::RADIX_DEC: scaled = (acc_reg << 3) + (acc_reg << 1);
            default:            scaled = acc_reg << 4;
        endcase
    end

    assign acc_next = scaled + digit;

    assign bin_msb = bin_sh_reg[VALUE_BITS-1];
    assign hex_top = hex_sh_reg[HEX_W-1 -: 4];

    assign status.bin_done = (bin_cnt_reg == '0) || bin_msb;
    assign status.hex_done = (hex_cnt_reg == '0) || (hex_top != 4'd0);
    assign status.bin_zero = (bin_cnt_reg == '0);
    assign status.bin_last = (bin_cnt_reg == BCNT_W'(1));
    assign status.hex_last = (hex_cnt_reg == HCNT_W'(1));

    always_comb begin
        unique case (cmd.kind)
            arc_pkg::KIND_VALUE: begin
                char_next = '0;
                last_next = status.bin_zero;
            end
            arc_pkg::KIND_BIN: begin
                char_next = arc_pkg::CH_ZERO + arc_pkg::CHAR_W'(bin_msb);
                last_next = 1'b0;
            end
            default: begin
                char_next = arc_pkg::hex_char(hex_top);
                last_next = status.hex_last;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= arc_pkg::RADIX_DEC;
            acc_reg   <= '0;
        end else begin
            if (cfg_we) begin
                radix_reg <= arc_pkg::radix_t'(cfg_wdata);
            end
            if (cmd.fold) begin
                acc_reg <= s_last_char ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fold && s_last_char) begin
            val_reg     <= acc_next;
            bin_sh_reg  <= acc_next;
            hex_sh_reg  <= HEX_W'(acc_next);
            bin_cnt_reg <= BCNT_W'(VALUE_BITS);
            hex_cnt_reg <= HCNT_W'(NIB);
        end else if (cmd.scan) begin
            if (!status.bin_done) begin
                bin_sh_reg  <= bin_sh_reg << 1;
                bin_cnt_reg <= bin_cnt_reg - BCNT_W'(1);
            end
            if (!status.hex_done) begin
                hex_sh_reg  <= hex_sh_reg << 4;
                hex_cnt_reg <= hex_cnt_reg - HCNT_W'(1);
            end
        end else if (cmd.emit && cmd.kind == arc_pkg::KIND_BIN) begin
            bin_sh_reg  <= bin_sh_reg << 1;
            bin_cnt_reg <= bin_cnt_reg - BCNT_W'(1);
        end else if (cmd.emit && cmd.kind == arc_pkg::KIND_HEX) begin
            hex_sh_reg  <= hex_sh_reg << 4;
            hex_cnt_reg <= hex_cnt_reg - HCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg   <= cmd.kind;
            number_reg <= arc_pkg::NUMBER_W'(val_reg);
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

    assign m_result_kind  = kind_reg;
    assign m_number_value = number_reg;
    assign m_digit_char   = char_reg;
    assign m_last_of_run  = last_reg;

endmodule

// File: design/arc_ctrl.sv
// ----------------------------------------------------------------------------
// ASCII radix converter controller
// Sequences folding, the leading-zero scan and the output transactions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last_char,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  arc_pkg::dp_status_t status,
    output arc_pkg::dp_cmd_t    cmd
);

    arc_pkg::state_t state_reg;
    arc_pkg::state_t state_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            arc_pkg::S_IDLE: begin
                if (s_valid && s_last_char) begin
                    state_next = arc_pkg::S_SCAN;
                end
            end
            arc_pkg::S_SCAN: begin
                if (status.bin_done && status.hex_done) begin
                    state_next = arc_pkg::S_REPORT;
                end
            end
            arc_pkg::S_REPORT: begin
                if (out_free) begin
                    state_next = status.bin_zero ? arc_pkg::S_IDLE : arc_pkg::S_BIN;
                end
            end
            arc_pkg::S_BIN: begin
                if (out_free && status.bin_last) begin
                    state_next = arc_pkg::S_HEX;
                end
            end
            arc_pkg::S_HEX: begin
                if (out_free && status.hex_last) begin
                    state_next = arc_pkg::S_IDLE;
                end
            end
            default: state_next = arc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.fold = 1'b0;
        cmd.scan = 1'b0;
        cmd.emit = 1'b0;
        cmd.kind = arc_pkg::KIND_VALUE;
        unique case (state_reg)
            arc_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.fold = s_valid;
            end
            arc_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
            end
            arc_pkg::S_REPORT: begin
                cmd.emit = out_free;
                cmd.kind = arc_pkg::KIND_VALUE;
            end
            arc_pkg::S_BIN: begin
                cmd.emit = out_free;
                cmd.kind = arc_pkg::KIND_BIN;
            end
            arc_pkg::S_HEX: begin
                cmd.emit = out_free;
                cmd.kind = arc_pkg::KIND_HEX;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= arc_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_IMP(a_emit_slot_free, aclk, aresetn, cmd.emit, !m_valid_reg || m_ready)
    `ASSERT_IMP(a_bin_has_bits, aclk, aresetn, state_reg == arc_pkg::S_BIN, !status.bin_zero)
    `ASSERT_IMP(a_hex_after_bin, aclk, aresetn, state_reg == arc_pkg::S_HEX, status.bin_zero)

endmodule

// File: design/ascii_radix_converter.sv
// ----------------------------------------------------------------------------
// ASCII radix converter
// Folds ASCII digits into a value and reports it as binary and hex digits.
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) carries one ASCII digit per transaction,
// most significant first, with s_last_char on the final digit. cfg_we and
// cfg_wdata set the input radix (0 binary, 1 decimal, 2 or 3 hexadecimal)
// and must only be written while the block is idle.
// A digit that is not last is folded into the accumulator, so digits can
// arrive every cycle. On the last digit the block scans the value for leading
// zeros, one bit and one nibble per cycle. After the scan, once the output
// register is free, the value report is sent on the result channel
// (m_valid/m_ready). It is followed by one transaction per significant binary
// digit and one per significant hex digit, at most one per cycle; a zero value
// gives only the report. No new digit is taken until the last result is loaded
// into the output register; a stalled receiver holds that register and the
// sequence.
// Reset sets the radix to decimal and clears the accumulator; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module ascii_radix_converter #(
    parameter int VALUE_BITS = arc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [arc_pkg::RADIX_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [arc_pkg::CHAR_W-1:0]   s_char_code,
    input  logic                         s_last_char,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [arc_pkg::KIND_W-1:0]   m_result_kind,
    output logic [arc_pkg::NUMBER_W-1:0] m_number_value,
    output logic [arc_pkg::CHAR_W-1:0]   m_digit_char,
    output logic                         m_last_of_run
);

    arc_pkg::dp_cmd_t    cmd;
    arc_pkg::dp_status_t status;

    arc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_char (s_last_char),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    arc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_char_code    (s_char_code),
        .s_last_char    (s_last_char),
        .cmd            (cmd),
        .status         (status),
        .m_result_kind  (m_result_kind),
        .m_number_value (m_number_value),
        .m_digit_char   (m_digit_char),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
